// ===== rtl/latency_running_statistics_top_defines.svh =====
// assertion macros for the latency statistics block
`ifndef LATENCY_RUNNING_STATISTICS_TOP_DEFINES_SVH
`define LATENCY_RUNNING_STATISTICS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define LRS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define LRS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRS_ASSERT(name, prop, msg)
`define LRS_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== rtl/lrs_pkg.sv =====
// shared types and constants for the latency statistics block
package lrs_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 32;
    localparam int DIV_STEPS           = 64;
    localparam int SQRT_STEPS          = 32;
    localparam int STEP_BITS           = 6;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] sample_us;
    } cmd_t;

    typedef struct packed {
        logic [31:0] min_latency;
        logic [31:0] max_latency;
        logic [31:0] mean_latency;
        logic [31:0] deviation;
        logic [31:0] sample_count;
    } stats_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV_MEAN,
        ST_DIV_SQ,
        ST_SQUARE,
        ST_DIFF,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/latency_running_statistics_top.sv =====
// latency running statistics: min, max, mean, deviation and count over samples
//
//  channel | dir | beat    | fields
//  --------+-----+---------+---------------------------------------------
//  cmd     | in  | cmd_t   | kind (add, report, clear), sample_us
//  stats   | out | stats_t | min, max, mean, deviation, count (report only)
//
//  an add passes through an accumulate state, a clear returns straight to idle;
//  a report with samples runs two 64-step restoring divides, one squaring,
//  one subtract and a 32-step square root, skipping the root when the spread
//  is not positive; the divide and root steps share one subtract/compare unit,
//  the squarings share one multiplier; a report without samples goes to done
//  rst_n clears the statistics and the control state at once, no sweep
//  cmd is accepted whenever the sequencer is idle, even while a finished
//  stats beat waits; a report that finishes holds until the output is free
`include "latency_running_statistics_top_defines.svh"

module latency_running_statistics_top #(
    parameter int SAMPLE_BITS = lrs_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  lrs_pkg::cmd_t   cmd,
    output logic            stats_valid,
    input  logic            stats_ready,
    output lrs_pkg::stats_t stats
);
    import lrs_pkg::*;

    // samples are cut to SAMPLE_BITS low bits
    localparam logic [31:0] SampleMask = 32'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [STEP_BITS-1:0] DivLast  = STEP_BITS'(DIV_STEPS - 1);
    localparam logic [STEP_BITS-1:0] SqrtLast = STEP_BITS'(SQRT_STEPS - 1);

    state_t state_reg, state_next;

    // running statistics
    logic [31:0] min_reg, max_reg, count_reg;
    logic [63:0] sum_reg, sqsum_reg;

    // working registers of the shared unit
    logic [63:0]          work_reg;   // dividend / quotient, then radicand
    logic [34:0]          rem_reg;    // partial remainder
    logic [31:0]          root_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [63:0]          sq_reg;     // sample square or squared mean
    logic [31:0]          mean_reg;
    logic [31:0]          dev_reg;

    logic   out_valid_reg;
    stats_t out_reg;

    logic        cmd_fire;
    logic        out_free;
    logic        load_out;
    logic [31:0] sample;

    // shared unit operands and result
    logic [34:0] rem_shift;
    logic [34:0] trial;
    logic [35:0] diff;
    logic        ge;

    logic [31:0] mul_a;
    logic [63:0] prod;

    assign sample   = cmd.sample_us & SampleMask;
    assign cmd_fire = cmd_valid && cmd_ready;
    assign out_free = !out_valid_reg || stats_ready;

    // one subtract/compare serves the divide steps and the root digits
    always_comb
    begin
        unique case (state_reg) inside
            ST_DIV_MEAN, ST_DIV_SQ:
            begin
                rem_shift = {rem_reg[33:0], work_reg[63]};
                trial     = {3'b000, count_reg};
            end
            ST_SQRT:
            begin
                rem_shift = {rem_reg[32:0], work_reg[63:62]};
                trial     = {1'b0, root_reg, 2'b01};
            end
            default:
            begin
                rem_shift = '0;
                trial     = '0;
            end
        endcase
        diff = {1'b0, rem_shift} - {1'b0, trial};
        ge   = !diff[35];
    end

    // one multiplier: sample square while idle, squared mean otherwise
    assign mul_a = (state_reg == ST_IDLE) ? sample : mean_reg;
    assign prod  = 64'(mul_a) * 64'(mul_a);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (cmd.kind)
                        KIND_ADD:    state_next = ST_ACCUM;
                        KIND_REPORT: state_next = (count_reg == '0) ? ST_DONE : ST_DIV_MEAN;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACCUM:    state_next = ST_IDLE;
            ST_DIV_MEAN: if (step_reg == DivLast) state_next = ST_DIV_SQ;
            ST_DIV_SQ:   if (step_reg == DivLast) state_next = ST_SQUARE;
            ST_SQUARE:   state_next = ST_DIFF;
            ST_DIFF:     state_next = (work_reg > sq_reg) ? ST_SQRT : ST_DONE;
            ST_SQRT:     if (step_reg == SqrtLast) state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        cmd_ready = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE: cmd_ready = 1'b1;
            ST_DONE: load_out  = out_free;
            default:
            begin
                cmd_ready = 1'b0;
                load_out  = 1'b0;
            end
        endcase
    end

    // control state and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            min_reg       <= '1;
            max_reg       <= '0;
            sum_reg       <= '0;
            sqsum_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (stats_ready)
                out_valid_reg <= 1'b0;

            if (cmd_fire && cmd.kind == KIND_ADD)
            begin
                if (sample < min_reg)
                    min_reg <= sample;
                if (sample > max_reg)
                    max_reg <= sample;
                sum_reg   <= sum_reg + 64'(sample);
                count_reg <= count_reg + 32'd1;
            end
            else if (cmd_fire && cmd.kind == KIND_CLEAR)
            begin
                min_reg   <= '1;
                max_reg   <= '0;
                sum_reg   <= '0;
                sqsum_reg <= '0;
                count_reg <= '0;
            end

            // the registered square is added in the cycle after the sample is taken
            if (state_reg == ST_ACCUM)
                sqsum_reg <= sqsum_reg + sq_reg;
        end
    end

    // datapath of the shared unit, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                sq_reg   <= prod;
                work_reg <= sum_reg;
                rem_reg  <= '0;
                step_reg <= '0;
            end
            ST_DIV_MEAN:
            begin
                if (step_reg == DivLast)
                begin
                    mean_reg <= {work_reg[30:0], ge};
                    work_reg <= sqsum_reg;
                    rem_reg  <= '0;
                    step_reg <= '0;
                end
                else
                begin
                    work_reg <= {work_reg[62:0], ge};
                    rem_reg  <= ge ? diff[34:0] : rem_shift;
                    step_reg <= step_reg + STEP_BITS'(1);
                end
            end
            ST_DIV_SQ:
            begin
                work_reg <= {work_reg[62:0], ge};
                rem_reg  <= ge ? diff[34:0] : rem_shift;
                step_reg <= step_reg + STEP_BITS'(1);
            end
            ST_SQUARE:
            begin
                sq_reg <= prod;
            end
            ST_DIFF:
            begin
                work_reg <= work_reg - sq_reg;
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= '0;
                dev_reg  <= '0;
            end
            ST_SQRT:
            begin
                work_reg <= {work_reg[61:0], 2'b00};
                rem_reg  <= ge ? diff[34:0] : rem_shift;
                root_reg <= {root_reg[30:0], ge};
                step_reg <= step_reg + STEP_BITS'(1);
                if (step_reg == SqrtLast)
                    dev_reg <= {root_reg[30:0], ge};
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase

        if (load_out)
        begin
            if (count_reg == '0)
            begin
                out_reg <= '0;
            end
            else
            begin
                out_reg.min_latency  <= min_reg;
                out_reg.max_latency  <= max_reg;
                out_reg.mean_latency <= mean_reg;
                out_reg.deviation    <= dev_reg;
                out_reg.sample_count <= count_reg;
            end
        end
    end

    assign stats_valid = out_valid_reg;
    assign stats       = out_reg;

    // a sample is always followed by its square accumulation
    `LRS_ASSERT(a_add_then_accum, cmd_fire && cmd.kind == KIND_ADD |=> state_reg == ST_ACCUM, "sample not followed by accumulate")
    // a new stats beat only comes out of the done state
    `LRS_ASSERT(a_out_from_done, $rose(stats_valid) |-> $past(state_reg) == ST_DONE, "stats beat without finished report")
    // with samples present the minimum never exceeds the maximum
    `LRS_ASSERT(a_min_le_max, count_reg != '0 |-> min_reg <= max_reg, "minimum above maximum")
    // reset holds the sequencer idle and the output empty
    `LRS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !stats_valid && state_reg == ST_IDLE, "not quiet in reset")

endmodule

// ===== tb/latency_running_statistics_checker.sv =====
// checker for the latency statistics block: predicts stats beats and compares them
`timescale 1ns / 1ps

module latency_running_statistics_checker #(
    parameter int SAMPLE_BITS = lrs_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_ready,
    input  lrs_pkg::cmd_t   cmd,
    input  logic            stats_valid,
    input  logic            stats_ready,
    input  lrs_pkg::stats_t stats,
    output int unsigned     fail_count,
    output int unsigned     reports_pending,
    output int unsigned     beats_checked
);
    import lrs_pkg::*;

    localparam logic [31:0] SAMPLE_MASK = 32'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic [31:0] seen_min;
    logic [31:0] seen_max;
    logic [63:0] sum_us;
    logic [63:0] sum_sq_us;
    logic [31:0] n_samples;

    stats_t      stats_due[$];
    stats_t      oldest;
    logic [31:0] sample;
    int unsigned mismatch_cnt;
    int unsigned beat_cnt;

    task automatic clear_totals();
        seen_min  = '1;
        seen_max  = '0;
        sum_us    = '0;
        sum_sq_us = '0;
        n_samples = '0;
    endtask

    // exact floor square root, one result bit at a time from the top
    function automatic logic [31:0] floor_root(input logic [63:0] v);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if ({32'd0, trial} * {32'd0, trial} <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic stats_t report_from_totals();
        stats_t      r;
        logic [63:0] mean_of_squares;
        logic [63:0] square_of_mean;
        r = '0;
        if (n_samples != 0)
        begin
            r.min_latency   = seen_min;
            r.max_latency   = seen_max;
            r.mean_latency  = 32'(sum_us / {32'd0, n_samples});
            mean_of_squares = sum_sq_us / {32'd0, n_samples};
            square_of_mean  = {32'd0, r.mean_latency} * {32'd0, r.mean_latency};
            if (mean_of_squares > square_of_mean)
                r.deviation = floor_root(mean_of_squares - square_of_mean);
        end
        r.sample_count = n_samples;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", field, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_totals();
            stats_due.delete();
            mismatch_cnt = 0;
            beat_cnt     = 0;
        end
        else
        begin
            // results first: a report taken at this edge cannot finish at it
            if (stats_valid && stats_ready)
            begin
                if (stats_due.size() == 0)
                begin
                    $error("stats beat with no report pending: count 0x%08h", stats.sample_count);
                    mismatch_cnt++;
                end
                else
                begin
                    oldest = stats_due.pop_front();
                    check_field("min_latency", oldest.min_latency, stats.min_latency);
                    check_field("max_latency", oldest.max_latency, stats.max_latency);
                    check_field("mean_latency", oldest.mean_latency, stats.mean_latency);
                    check_field("deviation", oldest.deviation, stats.deviation);
                    check_field("sample_count", oldest.sample_count, stats.sample_count);
                end
                beat_cnt++;
            end
            if (cmd_valid && cmd_ready)
            begin
                case (cmd.kind)
                    KIND_ADD:
                    begin
                        sample = cmd.sample_us & SAMPLE_MASK;
                        if (sample < seen_min)
                            seen_min = sample;
                        if (sample > seen_max)
                            seen_max = sample;
                        sum_us    = sum_us + {32'd0, sample};
                        sum_sq_us = sum_sq_us + {32'd0, sample} * {32'd0, sample};
                        n_samples = n_samples + 32'd1;
                    end
                    KIND_REPORT: stats_due.push_back(report_from_totals());
                    KIND_CLEAR:  clear_totals();
                    default:     ;
                endcase
            end
        end
        fail_count      <= mismatch_cnt;
        reports_pending <= stats_due.size();
        beats_checked   <= beat_cnt;
    end

endmodule

// ===== tb/latency_running_statistics_top_tb.sv =====
// testbench top for the latency statistics block: stimulus, output pacing and verdict
`timescale 1ns / 1ps

module latency_running_statistics_top_tb;
    import lrs_pkg::*;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 12;
    localparam int          RANDOM_ITEMS   = 1200;
    localparam int          MAX_GAP        = 17;
    // long output stall used to back the block up into its input
    localparam int          HOLD_CYCLES    = 800;
    // idle tail at the end that covers any late stats beat
    localparam int          TAIL_CYCLES    = 400;
    // quietest correct stretch is the output hold plus one report and two gaps
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam logic [1:0]  KIND_UNUSED    = 2'd3;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   cmd_valid;
    logic   cmd_ready;
    cmd_t   cmd;
    logic   stats_valid;
    logic   stats_ready;
    stats_t stats;

    int unsigned fail_count;
    int unsigned reports_pending;
    int unsigned beats_checked;

    // item tallies for the closing summary
    int unsigned n_add;
    int unsigned n_report;
    int unsigned n_clear;
    int unsigned n_unused;

    // sender runs without gaps while this is set
    bit sender_steady;
    // asks the stats side for one long hold-off
    bit hold_stats_req;

    always #(CLK_PERIOD / 2) clk = ~clk;

    latency_running_statistics_top #(
        .SAMPLE_BITS (SAMPLE_BITS_DEFAULT)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .stats_valid (stats_valid),
        .stats_ready (stats_ready),
        .stats       (stats)
    );

    latency_running_statistics_checker #(
        .SAMPLE_BITS (SAMPLE_BITS_DEFAULT)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd),
        .stats_valid     (stats_valid),
        .stats_ready     (stats_ready),
        .stats           (stats),
        .fail_count      (fail_count),
        .reports_pending (reports_pending),
        .beats_checked   (beats_checked)
    );

    // one cmd beat; valid stays up across back-to-back beats so it never
    // gets lowered and raised within the same step
    task automatic send_cmd(input cmd_t c, input int unsigned gap);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do @(posedge clk); while (!cmd_ready);
    endtask

    // builds a beat, picks its gap and keeps the tallies
    task automatic issue(input logic [1:0] kind, input logic [31:0] sample_us);
        cmd_t c;
        c.kind      = kind;
        c.sample_us = sample_us;
        case (kind)
            KIND_ADD:    n_add++;
            KIND_REPORT: n_report++;
            KIND_CLEAR:  n_clear++;
            default:     n_unused++;
        endcase
        send_cmd(c, sender_steady ? 0 : $urandom_range(0, MAX_GAP));
    endtask

    // stop offering beats until every predicted stats beat has come out;
    // the pending count is registered, so wait for the next edge before looking
    task automatic drain_stats();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (reports_pending != 0);
    endtask

    // latency values from a few regimes: anything, short, near the top, clustered
    function automatic logic [31:0] latency_draw(input logic [31:0] base);
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:       v = $urandom;
            1:       v = $urandom_range(0, 4095);
            2:       v = 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: v = base + $urandom_range(0, 127);
        endcase
        return v;
    endfunction

    // stats side: random hold-offs with steady stretches, plus the one long hold
    initial
    begin : stats_sink
        int unsigned stall;
        bit          steady;
        steady = 1'b0;
        stats_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                steady = !steady;
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_stats_req)
            begin
                hold_stats_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                stats_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            stats_ready <= 1'b1;
            do @(posedge clk); while (!stats_valid);
        end
    end

    // watchdog: too long without any beat on either channel
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (stats_valid && stats_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned random_items;
        int unsigned pick;
        logic [31:0] base;
        random_items   = 0;
        base           = $urandom;
        n_add          = 0;
        n_report       = 0;
        n_clear        = 0;
        n_unused       = 0;
        sender_steady  = 1'b0;
        hold_stats_req = 1'b0;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty report, both sample extremes, square sum wrap,
        // unused kind, clear, equal samples and alternating bit patterns
        issue(KIND_REPORT, 32'd0);
        issue(KIND_ADD, 32'd0);
        issue(KIND_REPORT, 32'd0);
        issue(KIND_ADD, 32'hFFFF_FFFF);
        issue(KIND_REPORT, 32'd0);
        // second max square pushes the 64-bit square sum past its top
        issue(KIND_ADD, 32'hFFFF_FFFF);
        issue(KIND_REPORT, 32'hFFFF_FFFF);
        issue(KIND_UNUSED, 32'hFFFF_FFFF);
        issue(KIND_UNUSED, 32'd0);
        issue(KIND_REPORT, 32'd0);
        issue(KIND_CLEAR, 32'hFFFF_FFFF);
        issue(KIND_REPORT, 32'd0);
        issue(KIND_ADD, 32'h8000_0000);
        issue(KIND_ADD, 32'h7FFF_FFFF);
        issue(KIND_ADD, 32'd1);
        issue(KIND_REPORT, 32'd0);
        issue(KIND_CLEAR, 32'd0);
        // identical samples give a zero spread
        repeat (3) issue(KIND_ADD, 32'd1000);
        issue(KIND_REPORT, 32'd0);
        issue(KIND_ADD, 32'hAAAA_AAAA);
        issue(KIND_ADD, 32'h5555_5555);
        issue(KIND_REPORT, 32'd0);
        issue(KIND_CLEAR, 32'd0);
        drain_stats();

        // back-pressure: the stats side holds off while reports keep coming, so one finished
        // result waits at the output, the next holds in the done state and the cmd side stalls
        hold_stats_req = 1'b1;
        sender_steady  = 1'b1;
        repeat (12)
        begin
            issue(KIND_ADD, latency_draw(base));
            issue(KIND_REPORT, $urandom);
        end
        drain_stats();

        // random: mostly add runs closed by reports, with clears and some noise
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items % 50 == 0)
                sender_steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                // ignored by the block, so not counted
                issue(KIND_UNUSED, $urandom);
            end
            else
            begin
                if (pick < 6)
                begin
                    issue(KIND_CLEAR, $urandom);
                    base = $urandom;
                end
                else if (pick < 18)
                    issue(KIND_REPORT, $urandom);
                else
                    issue(KIND_ADD, latency_draw(base));
                random_items++;
                if (random_items % 300 == 0)
                    drain_stats();
            end
        end
        issue(KIND_REPORT, $urandom);

        drain_stats();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d adds, %0d reports, %0d clears, %0d unused-kind beats",
                 n_add, n_report, n_clear, n_unused);
        $display("%0d stats beats compared, including a %0d-cycle output hold-off",
                 beats_checked, HOLD_CYCLES);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
